// ----- rtl/mst2_pkg.sv -----
// shared types and constants for the track 2 bit encoder
`default_nettype none

package mst2_pkg;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_FETCH  = 2'd2;

    localparam logic [3:0] SYM_START = 4'hB;
    localparam logic [3:0] SYM_END   = 4'hF;

    // data bits per symbol before the parity bit
    localparam logic [2:0] SYM_DATA_BITS = 3'd4;

    localparam logic [5:0] RESET_ZEROS = 6'd10;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_REVERSE_ORDER = 2'd0;
    localparam logic [1:0] REG_LEAD_ZEROS    = 2'd1;
    localparam logic [1:0] REG_TRAIL_ZEROS   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] digit;
    } in_beat_t;

    typedef struct packed {
        logic bit_value;
        logic last_bit;
        logic done_res;
        logic overflow;
    } out_beat_t;

endpackage

`default_nettype wire

// ----- rtl/mst2_ram.sv -----
// digit store: one write port, one registered read port
`default_nettype none

module mst2_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 4
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/magstripe_track2_bit_encoder.sv -----
// top level of the track 2 frame encoder
//
// Clear and append beats are taken in the idle state; a fetch beat issues the
// digit store read when it is taken and moves to the calc state, which forms
// the bit from the registered read data; no beat is taken until the bit is formed.
// A finished bit sits in an output register and the block keeps taking clear
// and append beats while it waits; a following fetch holds in the calc state
// until the output register is free. The digit store has no reset pass and
// is usable right after reset. Registers: reverse_order at 0x0, lead_zeros at
// 0x4, trail_zeros at 0x8.
`default_nettype none

module magstripe_track2_bit_encoder #(
    parameter int MAX_DIGITS = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire mst2_pkg::in_beat_t            s_data,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output mst2_pkg::out_beat_t                m_data,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mst2_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [mst2_pkg::PDATA_W-1:0]  pwdata,
    output logic      [mst2_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_START,
        PH_DIGITS,
        PH_END,
        PH_LRC,
        PH_TRAIL,
        PH_DONE
    } phase_t;

    state_t              state_reg;
    logic                m_valid_reg;
    mst2_pkg::out_beat_t m_data_reg;

    logic       reverse_order_reg;
    logic [5:0] lead_zeros_reg;
    logic [5:0] trail_zeros_reg;

    logic [CNT_W-1:0] digit_count_reg;
    phase_t           phase_reg,  phase_next;
    logic [5:0]       zero_cnt_reg, zero_cnt_next;
    logic [CNT_W-1:0] sym_idx_reg, sym_idx_next;
    logic [2:0]       bit_pos_reg, bit_pos_next;
    logic             parity_reg, parity_next;
    logic [3:0]       lrc_reg, lrc_next;
    logic             dropped_reg;

    mst2_pkg::out_beat_t calc_beat;

    logic             s_beat;
    logic             wr_en;
    logic             rd_en;
    logic [CNT_W-1:0] rd_idx;
    logic [3:0]       rd_data;
    logic             out_free;
    logic             cfg_wr;

    logic [3:0] sym;
    logic [6:0] trail_sum;
    logic       data_bit;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_beat   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign out_free = !m_valid_reg || m_ready;

    assign wr_en  = s_beat && (s_data.kind == mst2_pkg::KIND_APPEND)
                    && (digit_count_reg < MAX_CNT);
    assign rd_en  = s_beat && (s_data.kind == mst2_pkg::KIND_FETCH);
    assign rd_idx = reverse_order_reg ? (digit_count_reg - CNT_W'(1) - sym_idx_reg)
                                      : sym_idx_reg;

    mst2_ram #(
        .DEPTH  (MAX_DIGITS),
        .ADDR_W (ADDR_W),
        .WIDTH  (4)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (digit_count_reg[ADDR_W-1:0]),
        .wr_data (s_data.digit),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            mst2_pkg::REG_REVERSE_ORDER: prdata[0]   = reverse_order_reg;
            mst2_pkg::REG_LEAD_ZEROS:    prdata[5:0] = lead_zeros_reg;
            mst2_pkg::REG_TRAIL_ZEROS:   prdata[5:0] = trail_zeros_reg;
            default:                     prdata      = '0;
        endcase
    end

    // next bit of the frame
    always_comb begin
        phase_next    = phase_reg;
        zero_cnt_next = zero_cnt_reg;
        sym_idx_next  = sym_idx_reg;
        bit_pos_next  = bit_pos_reg;
        parity_next   = parity_reg;
        lrc_next      = lrc_reg;
        calc_beat     = '0;
        calc_beat.overflow = dropped_reg;
        sym       = rd_data;
        trail_sum = '0;
        data_bit  = 1'b0;

        if (phase_next == PH_LEAD && zero_cnt_next >= lead_zeros_reg) begin
            phase_next    = PH_START;
            zero_cnt_next = '0;
        end
        if (phase_next == PH_DIGITS && sym_idx_next >= digit_count_reg) begin
            phase_next = PH_END;
        end

        case (phase_next)
            PH_START: sym = mst2_pkg::SYM_START;
            PH_END:   sym = mst2_pkg::SYM_END;
            PH_LRC:   sym = lrc_reg;
            default:  sym = rd_data;
        endcase
        data_bit = sym[bit_pos_reg[1:0]];

        case (phase_next)
            PH_LEAD: begin
                zero_cnt_next = zero_cnt_next + 6'd1;
            end
            PH_TRAIL: begin
                trail_sum     = {1'b0, zero_cnt_next} + 7'd1;
                zero_cnt_next = trail_sum[5:0];
                if (trail_sum >= {1'b0, trail_zeros_reg}) begin
                    calc_beat.last_bit = 1'b1;
                    phase_next         = PH_DONE;
                end
            end
            PH_START, PH_DIGITS, PH_END, PH_LRC: begin
                if (bit_pos_reg < mst2_pkg::SYM_DATA_BITS) begin
                    calc_beat.bit_value = data_bit;
                    parity_next         = parity_reg ^ data_bit;
                    bit_pos_next        = bit_pos_reg + 3'd1;
                end else begin
                    calc_beat.bit_value = parity_reg;
                    bit_pos_next        = '0;
                    parity_next         = 1'b1;
                    if (phase_next != PH_LRC) begin
                        lrc_next = lrc_reg ^ sym;
                    end
                    case (phase_next)
                        PH_START: begin
                            phase_next   = PH_DIGITS;
                            sym_idx_next = '0;
                        end
                        PH_DIGITS: begin
                            sym_idx_next = sym_idx_reg + CNT_W'(1);
                        end
                        PH_END: begin
                            phase_next = PH_LRC;
                        end
                        default: begin
                            zero_cnt_next = '0;
                            if (trail_zeros_reg == 6'd0) begin
                                calc_beat.last_bit = 1'b1;
                                phase_next         = PH_DONE;
                            end else begin
                                phase_next = PH_TRAIL;
                            end
                        end
                    endcase
                end
            end
            default: begin
                calc_beat.done_res = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_valid_reg       <= 1'b0;
            reverse_order_reg <= 1'b0;
            lead_zeros_reg    <= mst2_pkg::RESET_ZEROS;
            trail_zeros_reg   <= mst2_pkg::RESET_ZEROS;
            digit_count_reg   <= '0;
            dropped_reg       <= 1'b0;
            phase_reg         <= PH_LEAD;
            zero_cnt_reg      <= '0;
            sym_idx_reg       <= '0;
            bit_pos_reg       <= '0;
            parity_reg        <= 1'b1;
            lrc_reg           <= '0;
        end else begin
            if (state_reg == ST_CALC && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr) begin
                case (paddr[3:2])
                    mst2_pkg::REG_REVERSE_ORDER: reverse_order_reg <= pwdata[0];
                    mst2_pkg::REG_LEAD_ZEROS:    lead_zeros_reg    <= pwdata[5:0];
                    mst2_pkg::REG_TRAIL_ZEROS:   trail_zeros_reg   <= pwdata[5:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        case (s_data.kind)
                            mst2_pkg::KIND_CLEAR: begin
                                digit_count_reg <= '0;
                                dropped_reg     <= 1'b0;
                                phase_reg       <= PH_LEAD;
                                zero_cnt_reg    <= '0;
                                sym_idx_reg     <= '0;
                                bit_pos_reg     <= '0;
                                parity_reg      <= 1'b1;
                                lrc_reg         <= '0;
                            end
                            mst2_pkg::KIND_APPEND: begin
                                if (digit_count_reg < MAX_CNT) begin
                                    digit_count_reg <= digit_count_reg + CNT_W'(1);
                                end else begin
                                    dropped_reg <= 1'b1;
                                end
                            end
                            mst2_pkg::KIND_FETCH: begin
                                state_reg <= ST_CALC;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CALC: begin
                    if (out_free) begin
                        phase_reg    <= phase_next;
                        zero_cnt_reg <= zero_cnt_next;
                        sym_idx_reg  <= sym_idx_next;
                        bit_pos_reg  <= bit_pos_next;
                        parity_reg   <= parity_next;
                        lrc_reg      <= lrc_next;
                        m_data_reg   <= calc_beat;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
